// ===== design/ccpv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the circle collision push vector unit.
// Holds widths, register indexes, pipeline record types and the step functions.
package ccpv_pkg;

	localparam int CoordWidth = 24;
	localparam int MagWidth   = CoordWidth;
	localparam int SqWidth    = 2 * MagWidth;
	localparam int RemWidth   = MagWidth + 3;
	localparam int PushWidth  = CoordWidth + 1;
	localparam int CfgWidth   = CoordWidth - 1;
	localparam int IdxWidth   = 2;

	localparam logic [IdxWidth-1:0] RegShapeIsBox = 2'd0;
	localparam logic [IdxWidth-1:0] RegHalfWidthX = 2'd1;
	localparam logic [IdxWidth-1:0] RegHalfWidthY = 2'd2;

	localparam logic [PushWidth-1:0] PushOne = PushWidth'(256);

	typedef struct packed {
		logic                hit;
		logic                zero;
		logic                axis;
		logic                sx;
		logic                sy;
		logic [MagWidth-1:0] ax;
		logic [MagWidth-1:0] ay;
		logic [MagWidth-1:0] lim;
	} side_t;

	typedef struct packed {
		logic [SqWidth-1:0]  n;
		logic [RemWidth-1:0] rem;
		logic [MagWidth-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [MagWidth-1:0] den;
		logic [SqWidth-1:0]  numx;
		logic [SqWidth-1:0]  numy;
		logic [MagWidth-1:0] remx;
		logic [MagWidth-1:0] remy;
		logic [MagWidth-1:0] qx;
		logic [MagWidth-1:0] qy;
	} div_t;

	function automatic sqrt_t sqrt_step(sqrt_t s);
		sqrt_t               o;
		logic [RemWidth-1:0] r;
		logic [RemWidth-1:0] t;
		o    = s;
		r    = {s.rem[RemWidth-3:0], s.n[SqWidth-1 -: 2]};
		t    = {1'b0, s.root, 2'b01};
		o.n  = {s.n[SqWidth-3:0], 2'b00};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {s.root[MagWidth-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[MagWidth-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_t div_step(div_t s);
		div_t              o;
		logic [MagWidth:0] tx;
		logic [MagWidth:0] ty;
		o      = s;
		tx     = {s.remx, s.numx[SqWidth-1]};
		ty     = {s.remy, s.numy[SqWidth-1]};
		o.numx = {s.numx[SqWidth-2:0], 1'b0};
		o.numy = {s.numy[SqWidth-2:0], 1'b0};
		if (tx >= {1'b0, s.den}) begin
			o.remx = MagWidth'(tx - {1'b0, s.den});
			o.qx   = {s.qx[MagWidth-2:0], 1'b1};
		end else begin
			o.remx = tx[MagWidth-1:0];
			o.qx   = {s.qx[MagWidth-2:0], 1'b0};
		end
		if (ty >= {1'b0, s.den}) begin
			o.remy = MagWidth'(ty - {1'b0, s.den});
			o.qy   = {s.qy[MagWidth-2:0], 1'b1};
		end else begin
			o.remy = ty[MagWidth-1:0];
			o.qy   = {s.qy[MagWidth-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ===== design/circle_collision_push_vector_unit.sv =====
`timescale 1ns / 1ps
// Top level of the circle collision push vector unit: a single deep pipeline.
// Depends on ccpv_pkg for widths, records and the square root and divide steps.
//
// Channel   Signals                                          Direction
// input     in_valid, in_ready, circle_x/y, radius, obj_x/y  in
// output    out_valid, out_ready, hit, push_x/y, axis_aligned out
// config    cfg_we, cfg_index, cfg_data                      in
//
// One item enters per cycle unless the output stalls; the pipeline has three front stages, 25 square
// root stages, one overlap stage, 25 divide stages and the output register.
// Reset clears all valid bits and loads the shape registers.
// When the output holds an item that is not taken, the whole pipeline stalls.
module circle_collision_push_vector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ccpv_pkg::IdxWidth-1:0]        cfg_index,
	input  logic [ccpv_pkg::CfgWidth-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ccpv_pkg::CoordWidth-1:0] circle_x,
	input  logic signed [ccpv_pkg::CoordWidth-1:0] circle_y,
	input  logic [ccpv_pkg::CfgWidth-1:0]        radius,
	input  logic signed [ccpv_pkg::CoordWidth-1:0] obj_x,
	input  logic signed [ccpv_pkg::CoordWidth-1:0] obj_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic signed [ccpv_pkg::PushWidth-1:0] push_x,
	output logic signed [ccpv_pkg::PushWidth-1:0] push_y,
	output logic                                 axis_aligned
);

	localparam int MW = ccpv_pkg::MagWidth;
	localparam int SW = ccpv_pkg::SqWidth;
	localparam int PW = ccpv_pkg::PushWidth;
	localparam int CW = ccpv_pkg::CoordWidth;

	logic                shape_is_box_q;
	logic [CW-2:0]       half_width_x_q;
	logic [CW-2:0]       half_width_y_q;
	logic                en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_is_box_q <= 1'b1;
			half_width_x_q <= '0;
			half_width_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccpv_pkg::RegShapeIsBox: shape_is_box_q <= cfg_data[0];
				ccpv_pkg::RegHalfWidthX: half_width_x_q <= cfg_data;
				ccpv_pkg::RegHalfWidthY: half_width_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: offsets.
	logic                 v_s1;
	logic signed [CW:0]   dx_s1, dy_s1;
	logic [MW-1:0]        r_s1;

	// Stage 2: clamp, magnitudes and limit.
	logic                 v_s2;
	ccpv_pkg::side_t      sd_s2;

	// Stage 3: squares.
	logic                 v_s3;
	ccpv_pkg::side_t      sd_s3;
	logic [SW-1:0]        a_s3, b_s3, l2_s3;
	logic                 inx_s3;

	// Square root and divide chains.
	logic                 sqv_s [0:MW];
	ccpv_pkg::side_t      sqd_s [0:MW];
	ccpv_pkg::sqrt_t      sq_s  [0:MW];
	logic                 amv_s;
	ccpv_pkg::side_t      amd_s;
	logic [MW-1:0]        amt_s, len_s;
	logic                 dvv_s [0:MW];
	ccpv_pkg::side_t      dvd_s [0:MW];
	ccpv_pkg::div_t       dv_s  [0:MW];

	logic signed [CW:0]   ex_c, ey_c;
	logic                 clx_c, cly_c;
	logic signed [CW:0]   hx_c, hy_c;
	logic [SW:0]          d2_c;
	ccpv_pkg::side_t      sdh_c;
	logic [SW-1:0]        prodx_c, prody_c;
	logic [PW-1:0]        px_c, py_c;

	always_comb begin
		hx_c  = (CW+1)'(half_width_x_q);
		hy_c  = (CW+1)'(half_width_y_q);
		clx_c = 1'b0;
		cly_c = 1'b0;
		ex_c  = dx_s1;
		ey_c  = dy_s1;
		if (shape_is_box_q) begin
			if (dx_s1 < -hx_c) begin
				ex_c  = dx_s1 + hx_c;
				clx_c = 1'b1;
			end else if (dx_s1 > hx_c) begin
				ex_c  = dx_s1 - hx_c;
				clx_c = 1'b1;
			end else begin
				ex_c  = '0;
			end
			if (dy_s1 < -hy_c) begin
				ey_c  = dy_s1 + hy_c;
				cly_c = 1'b1;
			end else if (dy_s1 > hy_c) begin
				ey_c  = dy_s1 - hy_c;
				cly_c = 1'b1;
			end else begin
				ey_c  = '0;
			end
		end
	end

	assign d2_c = {1'b0, a_s3} + {1'b0, b_s3};

	always_comb begin
		sdh_c     = sd_s3;
		sdh_c.hit = inx_s3 && (d2_c < {1'b0, l2_s3});
	end

	assign prodx_c = SW'(amd_s.ax) * SW'(amt_s);
	assign prody_c = SW'(amd_s.ay) * SW'(amt_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			amv_s <= 1'b0;
			for (int i = 0; i <= MW; i++) begin
				sqv_s[i] <= 1'b0;
				dvv_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			sqv_s[0] <= v_s3;
			for (int i = 1; i <= MW; i++) begin
				sqv_s[i] <= sqv_s[i-1];
				dvv_s[i] <= dvv_s[i-1];
			end
			amv_s    <= sqv_s[MW];
			dvv_s[0] <= amv_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (CW+1)'(circle_x) - (CW+1)'(obj_x);
			dy_s1 <= (CW+1)'(circle_y) - (CW+1)'(obj_y);
			r_s1  <= MW'(radius);

			sd_s2.hit  <= 1'b0;
			sd_s2.zero <= (ex_c == '0) && (ey_c == '0);
			sd_s2.axis <= clx_c ^ cly_c;
			sd_s2.sx   <= ex_c[CW];
			sd_s2.sy   <= ey_c[CW];
			sd_s2.ax   <= MW'(ex_c[CW] ? -ex_c : ex_c);
			sd_s2.ay   <= MW'(ey_c[CW] ? -ey_c : ey_c);
			sd_s2.lim  <= shape_is_box_q ? r_s1 : r_s1 + MW'(half_width_x_q);

			sd_s3  <= sd_s2;
			a_s3   <= sd_s2.ax * sd_s2.ax;
			b_s3   <= sd_s2.ay * sd_s2.ay;
			l2_s3  <= sd_s2.lim * sd_s2.lim;
			inx_s3 <= (sd_s2.ax < sd_s2.lim) && (sd_s2.ay < sd_s2.lim);

			sqd_s[0]     <= sdh_c;
			sq_s[0].n    <= d2_c[SW-1:0];
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			for (int i = 1; i <= MW; i++) begin
				sqd_s[i] <= sqd_s[i-1];
				sq_s[i]  <= ccpv_pkg::sqrt_step(sq_s[i-1]);
				dvd_s[i] <= dvd_s[i-1];
				dv_s[i]  <= ccpv_pkg::div_step(dv_s[i-1]);
			end

			amd_s <= sqd_s[MW];
			len_s <= sq_s[MW].root;
			amt_s <= sqd_s[MW].lim - sq_s[MW].root;

			dvd_s[0]      <= amd_s;
			dv_s[0].den   <= len_s;
			dv_s[0].numx  <= {prodx_c[MW-1:0], {MW{1'b0}}};
			dv_s[0].numy  <= {prody_c[MW-1:0], {MW{1'b0}}};
			dv_s[0].remx  <= prodx_c[SW-1:MW];
			dv_s[0].remy  <= prody_c[SW-1:MW];
			dv_s[0].qx    <= '0;
			dv_s[0].qy    <= '0;
		end
	end

	always_comb begin
		px_c = '0;
		py_c = '0;
		if (dvd_s[MW].hit) begin
			if (dvd_s[MW].zero) begin
				px_c = ccpv_pkg::PushOne;
			end else begin
				px_c = dvd_s[MW].sx ? -PW'(dv_s[MW].qx) : PW'(dv_s[MW].qx);
				py_c = dvd_s[MW].sy ? -PW'(dv_s[MW].qy) : PW'(dv_s[MW].qy);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvv_s[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit          <= dvd_s[MW].hit;
			push_x       <= px_c;
			push_y       <= py_c;
			axis_aligned <= dvd_s[MW].hit && !dvd_s[MW].zero && dvd_s[MW].axis;
		end
	end

	a_no_hit_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> push_x == '0 && push_y == '0 && !axis_aligned)
		else $error("push without hit");
	a_axis_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && axis_aligned |-> hit && shape_is_box_q)
		else $error("axis flag without box hit");
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output side");
	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && dvv_s[MW] |=> out_valid)
		else $error("item lost at output register");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circle_collision_push_vector_unit.
// Streams collision queries through the unit under bursty input and stalled output.
// Each result is checked against a local push vector predictor. Depends on ccpv_pkg.
module tb;
	localparam int IdxWidth   = ccpv_pkg::IdxWidth;
	localparam int CoordWidth = ccpv_pkg::CoordWidth;
	localparam int CfgWidth   = ccpv_pkg::CfgWidth;
	localparam int PushWidth  = ccpv_pkg::PushWidth;

	localparam logic [IdxWidth-1:0] RegUnused = 2'd3;
	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles   = 80;

	typedef struct {
		logic signed [CoordWidth-1:0] cx;
		logic signed [CoordWidth-1:0] cy;
		logic [CfgWidth-1:0]          rad;
		logic signed [CoordWidth-1:0] ox;
		logic signed [CoordWidth-1:0] oy;
	} query_t;

	typedef struct {
		logic                        hit;
		logic signed [PushWidth-1:0] px;
		logic signed [PushWidth-1:0] py;
		logic                        axis;
	} push_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IdxWidth-1:0] cfg_index = '0;
	logic [CfgWidth-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CoordWidth-1:0] circle_x = '0;
	logic signed [CoordWidth-1:0] circle_y = '0;
	logic [CfgWidth-1:0] radius = '0;
	logic signed [CoordWidth-1:0] obj_x = '0;
	logic signed [CoordWidth-1:0] obj_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [PushWidth-1:0] push_x;
	logic signed [PushWidth-1:0] push_y;
	logic axis_aligned;

	circle_collision_push_vector_unit uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic                shape_box = 1'b1;
	logic [CfgWidth-1:0] half_x = '0;
	logic [CfgWidth-1:0] half_y = '0;

	query_t pending_queries[$];
	push_t  expected_pushes[$];
	bit     hold_input = 1'b0;
	int     errors = 0;
	int     checked = 0;
	int     hits_seen = 0;
	int     axis_seen = 0;
	int     queries_sent = 0;

	function automatic push_t predict_push(query_t q);
		push_t             p;
		longint            dx, dy, ex, ey, hx, hy, cx, cy, px, py;
		longint unsigned   lim, ax, ay, l2, a, b, d2, n, res, bt, len;
		int                clamps;
		bit                hit_now, axis;
		dx = longint'(q.cx) - longint'(q.ox);
		dy = longint'(q.cy) - longint'(q.oy);
		ex = dx;
		ey = dy;
		px = 0;
		py = 0;
		axis = 1'b0;
		hit_now = 1'b0;
		d2 = 0;
		if (shape_box) begin
			hx = longint'(half_x);
			hy = longint'(half_y);
			cx = dx;
			cy = dy;
			clamps = 0;
			if (cx < -hx) begin cx = -hx; clamps++; end
			if (cy < -hy) begin cy = -hy; clamps++; end
			if (cx > hx) begin cx = hx; clamps++; end
			if (cy > hy) begin cy = hy; clamps++; end
			ex = dx - cx;
			ey = dy - cy;
			lim = longint'(q.rad);
			axis = (clamps == 1);
		end else begin
			lim = longint'(q.rad) + longint'(half_x);
		end
		ax = (ex < 0) ? -ex : ex;
		ay = (ey < 0) ? -ey : ey;
		if (ax < lim && ay < lim) begin
			l2 = lim * lim;
			a = ax * ax;
			b = ay * ay;
			if (b < l2 - a) begin
				hit_now = 1'b1;
				d2 = a + b;
			end
		end
		if (!hit_now) begin
			axis = 1'b0;
		end else if (ex == 0 && ey == 0) begin
			px = 256;
			axis = 1'b0;
		end else begin
			n = d2;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > n) bt >>= 2;
			while (bt != 0) begin
				if (n >= res + bt) begin
					n -= res + bt;
					res = (res >> 1) + bt;
				end else begin
					res >>= 1;
				end
				bt >>= 2;
			end
			len = res;
			px = longint'(ax * (lim - len) / len);
			py = longint'(ay * (lim - len) / len);
			if (ex < 0) px = -px;
			if (ey < 0) py = -py;
		end
		if (px > (64'sd1 << CoordWidth) - 1) px = (64'sd1 << CoordWidth) - 1;
		if (px < -(64'sd1 << CoordWidth)) px = -(64'sd1 << CoordWidth);
		if (py > (64'sd1 << CoordWidth) - 1) py = (64'sd1 << CoordWidth) - 1;
		if (py < -(64'sd1 << CoordWidth)) py = -(64'sd1 << CoordWidth);
		p.hit  = hit_now;
		p.px   = PushWidth'(px);
		p.py   = PushWidth'(py);
		p.axis = axis;
		return p;
	endfunction

	function automatic logic signed [CoordWidth-1:0] sat_coord(longint v);
		if (v > (64'sd1 << (CoordWidth - 1)) - 1) v = (64'sd1 << (CoordWidth - 1)) - 1;
		if (v < -(64'sd1 << (CoordWidth - 1))) v = -(64'sd1 << (CoordWidth - 1));
		return CoordWidth'(v);
	endfunction

	function automatic query_t random_query();
		query_t q;
		longint span, ox, oy;
		int     sel;
		sel = $urandom_range(0, 9);
		q.cx = CoordWidth'($urandom);
		q.cy = CoordWidth'($urandom);
		q.ox = CoordWidth'($urandom);
		q.oy = CoordWidth'($urandom);
		case ($urandom_range(0, 3))
			0: q.rad = CfgWidth'($urandom_range(0, 255));
			1: q.rad = CfgWidth'($urandom_range(0, 65535));
			2: q.rad = CfgWidth'($urandom);
			default: q.rad = CfgWidth'($urandom_range(0, 4095));
		endcase
		if (sel >= 2) begin
			span = longint'(q.rad) + longint'(half_x) + longint'(half_y) + 16;
			span = span + span / 2;
			ox = longint'(q.ox);
			oy = longint'(q.oy);
			if (sel >= 6) begin
				ox = ox / 2;
				oy = oy / 2;
			end
			q.ox = CoordWidth'(ox);
			q.oy = CoordWidth'(oy);
			q.cx = sat_coord(ox + longint'($urandom_range(0, 32'(2 * span))) - span);
			q.cy = sat_coord(oy + longint'($urandom_range(0, 32'(2 * span))) - span);
			if (sel == 9) q.cy = q.oy;
		end
		return q;
	endfunction

	task automatic add_query(int cx, int cy, int rad, int ox, int oy);
		query_t q;
		q.cx = CoordWidth'(cx);
		q.cy = CoordWidth'(cy);
		q.rad = CfgWidth'(rad);
		q.ox = CoordWidth'(ox);
		q.oy = CoordWidth'(oy);
		pending_queries.push_back(q);
	endtask

	task automatic add_random(int count);
		repeat (count) pending_queries.push_back(random_query());
	endtask

	task automatic wait_idle();
		while (pending_queries.size() != 0 || in_valid || expected_pushes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [IdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			ccpv_pkg::RegShapeIsBox: shape_box = value[0];
			ccpv_pkg::RegHalfWidthX: half_x = value;
			ccpv_pkg::RegHalfWidthY: half_y = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic box, logic [CfgWidth-1:0] hx, logic [CfgWidth-1:0] hy,
			int count);
		wait_idle();
		write_reg(ccpv_pkg::RegShapeIsBox, CfgWidth'(box));
		write_reg(ccpv_pkg::RegHalfWidthX, hx);
		write_reg(ccpv_pkg::RegHalfWidthY, hy);
		add_random(count);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, checked, got, want);
		errors++;
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_pushes.push_back(predict_push(pending_queries.pop_front()));
				queries_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_queries.size() != 0 && !hold_input) begin
				in_valid <= 1'b1;
				circle_x <= pending_queries[0].cx;
				circle_y <= pending_queries[0].cy;
				radius <= pending_queries[0].rad;
				obj_x <= pending_queries[0].ox;
				obj_y <= pending_queries[0].oy;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result taken and changes its stall pattern periodically.
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pushes.size() == 0) begin
					report("unexpected result hit", hit, 0);
				end else begin
					push_t want;
					want = expected_pushes.pop_front();
					if (hit !== want.hit) report("hit", hit, want.hit);
					if (push_x !== want.px) report("push_x", push_x, want.px);
					if (push_y !== want.py) report("push_y", push_y, want.py);
					if (axis_aligned !== want.axis)
						report("axis_aligned", axis_aligned, want.axis);
					hits_seen += want.hit;
					axis_seen += want.axis;
					checked++;
				end
			end
			stall_cnt++;
			if (stall_cnt >= 200) begin
				stall_cnt = 0;
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 9) == 0);
				default: out_ready <= (stall_cnt % 16) < 12;
			endcase
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	localparam int MaxC = 8388607;
	localparam int MinC = -8388608;
	localparam int MaxR = 8388607;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Reset shape is a box of zero size, so the object is a single point.
		add_query(0, 0, 0, 0, 0);
		add_query(10, 0, 0, 0, 0);
		add_query(100, 50, 512, 0, 0);
		add_query(MaxC, MaxC, MaxR, MinC, MinC);
		add_random(30);
		wait_idle();
		write_reg(RegUnused, CfgWidth'($urandom));
		write_reg(ccpv_pkg::RegHalfWidthX, CfgWidth'(1000));
		write_reg(ccpv_pkg::RegHalfWidthY, CfgWidth'(500));
		add_query(0, 0, 256, 0, 0);
		add_query(1200, 0, 256, 0, 0);
		add_query(1256, 0, 256, 0, 0);
		add_query(-1255, 0, 256, 0, 0);
		add_query(0, 700, 256, 0, 0);
		add_query(0, -756, 256, 0, 0);
		add_query(1100, 600, 256, 0, 0);
		add_query(-1100, -600, 256, 0, 0);
		add_query(MinC, MinC, MaxR, MaxC, MaxC);
		add_query(MaxC, MinC, MaxR, MinC, MaxC);
		add_query(MaxC, 0, 0, 0, 0);
		add_query(500, 200, MaxR, 0, 0);
		add_query(MinC, MaxC, 0, MinC, MaxC);
		// Let everything drain before taking new items.
		hold_input = 1'b1;
		while (expected_pushes.size() != 0 || in_valid) @(posedge clk);
		hold_input = 1'b0;
		add_random(80);
		run_phase(1'b1, CfgWidth'($urandom_range(0, 4095)),
			CfgWidth'($urandom_range(0, 4095)), 100);
		run_phase(1'b1, CfgWidth'(MaxR), CfgWidth'(MaxR), 60);
		run_phase(1'b1, '0, CfgWidth'(MaxR), 60);
		run_phase(1'b0, '0, '0, 60);
		add_query(0, 0, 300, 0, 0);
		add_query(MaxC, MaxC, MaxR, MinC, MinC);
		run_phase(1'b0, CfgWidth'(MaxR), '0, 60);
		add_query(MaxC, 0, MaxR, MinC, 0);
		add_query(MinC, MinC, MaxR, MinC, MinC);
		run_phase(1'b0, CfgWidth'($urandom_range(0, 65535)), CfgWidth'($urandom), 120);
		run_phase(1'b1, CfgWidth'($urandom_range(0, 300)),
			CfgWidth'($urandom_range(0, 300)), 100);
		wait_idle();
		$display("%0d queries checked over box and circle shapes, %0d hits, %0d axis aligned",
			checked, hits_seen, axis_seen);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
